// ===== src/assert_macros.svh =====
// assertion macros shared by the transcoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define UTJS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at a rising clock edge outside reset
`define UTJS_NEVER(lbl, clk, rst_n, cond, msg) \
    `UTJS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== src/utjs_pkg.sv =====
// shared types and constants of the utf-16 to json utf-8 transcoder
`timescale 1ns / 1ps

package utjs_pkg;

    // longest byte run one code unit can cause
    localparam int MAX_RUN = 9;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    // string and surrogate tracking state
    typedef struct packed {
        logic       in_str;
        logic       pending;
        logic [9:0] high_bits;
    } t_str_state;

    // byte run for one code unit, byte 0 goes out first
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [CNT_W-1:0]        len;
        logic                    closes;
    } t_run;

endpackage

// ===== src/utf16_to_json_utf8_string_core.sv =====
// top level: utf-16 code units in, quoted json string bytes in utf-8 out
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+-------------------
//  unit    | in        | i_code_unit                               | i_valid / o_stall
//  byte    | out       | o_out_byte o_last_of_run o_closes_string  | o_valid / i_stall
//
// a unit is registered, encoded combinationally into a run of 0 to 9 bytes,
// and the run is loaded into a shift buffer that hands out one byte a cycle
// while i_stall is low; a unit that makes one byte then sustains one unit a cycle;
// a run of n bytes holds the buffer, and so the input, until its last byte is taken.
// reset (synchronous, active low) closes any open string and drops held items.
// output stall freezes the byte buffer; once the unit register is also full
// o_stall rises in the same cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf16_to_json_utf8_string_core
    import utjs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_code_unit,
    input  logic        i_valid,
    output logic        o_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_closes_string,
    output logic        o_valid,
    input  logic        i_stall
);

    logic                    r_in_valid, n_in_valid;
    logic [15:0]             r_unit, n_unit;
    t_str_state              r_state, n_state;
    logic                    r_run_valid, n_run_valid;
    logic [MAX_RUN-1:0][7:0] r_bytes, n_bytes;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_close, n_close;

    t_run       gen_run;
    t_str_state gen_state;
    logic       in_acc;
    logic       out_acc;
    logic       run_free;
    logic       advance;

    utjs_run_gen u_run_gen (
        .i_code_unit (r_unit),
        .i_state     (r_state),
        .o_run       (gen_run),
        .o_state     (gen_state)
    );

    // handshake control
    assign out_acc  = r_run_valid && !i_stall;
    assign run_free = !r_run_valid || (out_acc && (r_cnt == CNT_W'(1)));
    assign advance  = r_in_valid && run_free;
    assign o_stall  = r_in_valid && !run_free;
    assign in_acc   = i_valid && !o_stall;

    // unit register and string state
    always_comb begin
        n_in_valid = r_in_valid;
        n_unit     = r_unit;
        n_state    = r_state;
        if (advance) begin
            n_in_valid = 1'b0;
            n_state    = gen_state;
        end
        if (in_acc) begin
            n_in_valid = 1'b1;
            n_unit     = i_code_unit;
        end
    end

    // byte buffer: load a fresh run or shift one byte out
    always_comb begin
        n_run_valid = r_run_valid;
        n_bytes     = r_bytes;
        n_cnt       = r_cnt;
        n_close     = r_close;
        if (out_acc) begin
            for (int k = 0; k < MAX_RUN - 1; k++) n_bytes[k] = r_bytes[k+1];
            n_bytes[MAX_RUN-1] = 8'd0;
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_run_valid = 1'b0;
            end
        end
        if (advance && (gen_run.len != '0)) begin
            n_run_valid = 1'b1;
            n_bytes     = gen_run.bytes;
            n_cnt       = gen_run.len;
            n_close     = gen_run.closes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_run_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_run_valid <= n_run_valid;
            r_cnt       <= n_cnt;
        end
        r_unit  <= n_unit;
        r_bytes <= n_bytes;
        r_close <= n_close;
    end

    // output item
    assign o_valid         = r_run_valid;
    assign o_out_byte      = r_bytes[0];
    assign o_last_of_run   = (r_cnt == CNT_W'(1));
    assign o_closes_string = r_close && (r_cnt == CNT_W'(1));

    // checks
    `UTJS_NEVER(a_cnt_range, i_clk, i_rst_n, r_run_valid && ((r_cnt == '0) || (r_cnt > CNT_W'(MAX_RUN))), "byte count out of range")
    `UTJS_ASSERT(a_unit_held, i_clk, i_rst_n, (r_in_valid && o_stall) |=> (r_in_valid && $stable(r_unit)), "stalled unit register changed")
    `UTJS_ASSERT(a_run_drain, i_clk, i_rst_n, (out_acc && (r_cnt > CNT_W'(1))) |=> (r_run_valid && (r_cnt == $past(r_cnt) - CNT_W'(1))), "run lost bytes while draining")
    `UTJS_ASSERT(a_close_last, i_clk, i_rst_n, (o_valid && o_closes_string) |-> (o_last_of_run && (o_out_byte == 8'h22)), "closing quote misplaced")

endmodule

// ===== src/utjs_run_gen.sv =====
// combinational encoder: one code unit to its run of json utf-8 bytes
`timescale 1ns / 1ps

module utjs_run_gen
    import utjs_pkg::*;
(
    input  logic [15:0] i_code_unit,
    input  t_str_state  i_state,
    output t_run        o_run,
    output t_str_state  o_state
);

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5C;
    localparam logic [7:0] REPL0  = 8'hEF;
    localparam logic [7:0] REPL1  = 8'hBF;
    localparam logic [7:0] REPL2  = 8'hBD;

    // leading segment codes: nothing, opening quote, replacement char
    localparam logic [1:0] PRE_NONE  = 2'd0;
    localparam logic [1:0] PRE_QUOTE = 2'd1;
    localparam logic [1:0] PRE_REPL  = 2'd3;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        d = (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
        return d;
    endfunction

    logic              is_zero;
    logic              is_high;
    logic              is_low;
    logic              pend;
    logic [1:0]        pre;
    logic [5:0][7:0]   main;
    logic [2:0]        main_len;
    logic              closes;
    logic [20:0]       cp;
    logic [6:0]        c;

    assign is_zero = (i_code_unit == 16'd0);
    assign is_high = (i_code_unit[15:10] == 6'b110110);
    assign is_low  = (i_code_unit[15:10] == 6'b110111);
    assign pend    = i_state.in_str & i_state.pending;
    assign cp      = 21'h10000 + {1'b0, i_state.high_bits, i_code_unit[9:0]};
    assign c       = i_code_unit[6:0];

    // leading segment: opening quote, or a held high surrogate left unpaired
    always_comb begin
        if (!i_state.in_str) begin
            pre = PRE_QUOTE;
        end else if (pend && !is_low) begin
            pre = PRE_REPL;
        end else begin
            pre = PRE_NONE;
        end
    end

    // main segment for the unit itself
    always_comb begin
        main     = '0;
        main_len = 3'd0;
        closes   = 1'b0;
        priority if (is_zero) begin
            main[0]  = QUOTE;
            main_len = 3'd1;
            closes   = 1'b1;
        end else if (is_high) begin
            main_len = 3'd0;
        end else if (is_low) begin
            if (pend) begin
                main[0]  = {5'b11110, cp[20:18]};
                main[1]  = {2'b10, cp[17:12]};
                main[2]  = {2'b10, cp[11:6]};
                main[3]  = {2'b10, cp[5:0]};
                main_len = 3'd4;
            end else begin
                main[0]  = REPL0;
                main[1]  = REPL1;
                main[2]  = REPL2;
                main_len = 3'd3;
            end
        end else if (i_code_unit[15:7] == 9'd0) begin
            // ascii with json escapes
            unique case (c)
                7'h22: begin
                    main[0] = BSLASH; main[1] = QUOTE;  main_len = 3'd2;
                end
                7'h5C: begin
                    main[0] = BSLASH; main[1] = BSLASH; main_len = 3'd2;
                end
                7'h0A: begin
                    main[0] = BSLASH; main[1] = 8'h6E;  main_len = 3'd2;
                end
                7'h0D: begin
                    main[0] = BSLASH; main[1] = 8'h72;  main_len = 3'd2;
                end
                7'h09: begin
                    main[0] = BSLASH; main[1] = 8'h74;  main_len = 3'd2;
                end
                7'h08: begin
                    main[0] = BSLASH; main[1] = 8'h62;  main_len = 3'd2;
                end
                7'h0C: begin
                    main[0] = BSLASH; main[1] = 8'h66;  main_len = 3'd2;
                end
                default: begin
                    if (c < 7'h20) begin
                        main[0]  = BSLASH;
                        main[1]  = 8'h75;
                        main[2]  = 8'h30;
                        main[3]  = 8'h30;
                        main[4]  = hex_digit({3'd0, c[4]});
                        main[5]  = hex_digit(c[3:0]);
                        main_len = 3'd6;
                    end else begin
                        main[0]  = {1'b0, c};
                        main_len = 3'd1;
                    end
                end
            endcase
        end else if (i_code_unit[15:11] == 5'd0) begin
            main[0]  = {3'b110, i_code_unit[10:6]};
            main[1]  = {2'b10, i_code_unit[5:0]};
            main_len = 3'd2;
        end else begin
            main[0]  = {4'b1110, i_code_unit[15:12]};
            main[1]  = {2'b10, i_code_unit[11:6]};
            main[2]  = {2'b10, i_code_unit[5:0]};
            main_len = 3'd3;
        end
    end

    // join leading and main segments
    always_comb begin
        o_run.bytes = '0;
        unique case (pre)
            PRE_NONE: begin
                for (int k = 0; k < 6; k++) o_run.bytes[k] = main[k];
            end
            PRE_QUOTE: begin
                o_run.bytes[0] = QUOTE;
                for (int k = 0; k < 6; k++) o_run.bytes[k+1] = main[k];
            end
            PRE_REPL: begin
                o_run.bytes[0] = REPL0;
                o_run.bytes[1] = REPL1;
                o_run.bytes[2] = REPL2;
                for (int k = 0; k < 6; k++) o_run.bytes[k+3] = main[k];
            end
            default: begin
                o_run.bytes = '0;
            end
        endcase
        o_run.len    = CNT_W'(pre) + CNT_W'(main_len);
        o_run.closes = closes;
    end

    // state after this unit
    always_comb begin
        o_state.in_str    = !is_zero;
        o_state.pending   = is_high;
        o_state.high_bits = is_high ? i_code_unit[9:0] : 10'd0;
    end

endmodule
